>>> rtl/quadratic_root_solver_assert.svh
// Assertion macros for the quadratic root solver.
// Each expects signals named clk and rst in the enclosing module.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quadratic_root_solver: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quadratic_root_solver: next-cycle check failed");

`endif

>>> rtl/qrs_pkg.sv
// ---------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types for the quadratic root solver pipeline.
// ---------------------------------------------------------------------------
package qrs_pkg;

  // Default word and fraction widths (Q16.16)
  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Per-request control flags carried alongside the data
  typedef struct packed {
    logic dneg;   // discriminant negative
    logic azero;  // leading coefficient is zero
  } qrs_flags_t;

endpackage

>>> rtl/quadratic_root_solver.sv
// ---------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ---------------------------------------------------------------------------
// One request enters per clock whenever start is high; busy is high only
// while rst is asserted. Each request produces exactly one result, presented
// for one cycle with done high, after the front end, the square root pipeline
// (one root bit per stage), the numerator setup register, the restoring
// divider (one quotient bit per stage) and the result register. Words are
// Q16.16 by default; results leave in request order and cannot be held off.
// ---------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int WORD_BITS     = qrs_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] coef_a,
  input  logic signed [WORD_BITS-1:0] coef_b,
  input  logic signed [WORD_BITS-1:0] coef_c,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] first_real,
  output logic signed [WORD_BITS-1:0] first_imag,
  output logic signed [WORD_BITS-1:0] second_real,
  output logic signed [WORD_BITS-1:0] second_imag,
  output logic                        complex_pair,
  output logic                        leading_zero,
  output logic                        saturated
);

  `include "quadratic_root_solver_assert.svh"

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int RB = 2*W + 2 + 2*F;
  localparam int SB = RB / 2;
  localparam int NM = W + F + 2;
  localparam int NW = NM + 1;

  // front end: products and discriminant
  logic                fr_valid;
  logic signed [W-1:0] fr_a, fr_b;
  logic [RB-1:0]       fr_rad;
  qrs_pkg::qrs_flags_t fr_flags;

  assign busy = rst;

  qrs_front #(.W(W), .F(F)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_a      (coef_a),
    .in_b      (coef_b),
    .in_c      (coef_c),
    .out_valid (fr_valid),
    .out_a     (fr_a),
    .out_b     (fr_b),
    .out_rad   (fr_rad),
    .out_flags (fr_flags)
  );

  // square root of the scaled discriminant
  logic                sq_valid;
  logic signed [W-1:0] sq_a, sq_b;
  logic [SB-1:0]       sq_root;
  qrs_pkg::qrs_flags_t sq_flags;

  qrs_sqrt #(.W(W), .F(F)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_a      (fr_a),
    .in_b      (fr_b),
    .in_rad    (fr_rad),
    .in_flags  (fr_flags),
    .out_valid (sq_valid),
    .out_a     (sq_a),
    .out_b     (sq_b),
    .out_root  (sq_root),
    .out_flags (sq_flags)
  );

  // numerator setup: -B*2^F +- S, or -B*2^F and S for a conjugate pair
  logic signed [NW-1:0] nbx, sx, n1, n2;
  logic [NW-1:0]        n1m, n2m, nbm;
  logic [W-1:0]         amag;
  logic                 sgn_a;
  logic                 st_valid;
  logic [NM-1:0]        st_num0, st_num1;
  logic                 st_neg0, st_neg1;
  logic [W:0]           st_den;
  qrs_pkg::qrs_flags_t  st_flags;

  assign sgn_a = sq_a[W-1];
  assign nbx   = -(NW'(sq_b)) <<< F;
  assign sx    = signed'(NW'(sq_root));
  assign n1    = nbx + sx;
  assign n2    = nbx - sx;
  assign n1m   = n1[NW-1] ? NW'(-n1) : NW'(n1);
  assign n2m   = n2[NW-1] ? NW'(-n2) : NW'(n2);
  assign nbm   = nbx[NW-1] ? NW'(-nbx) : NW'(nbx);
  assign amag  = sgn_a ? W'(-sq_a) : W'(sq_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_den   <= {amag, 1'b0};
    st_flags <= sq_flags;
    if (sq_flags.dneg) begin
      st_num0 <= nbm[NM-1:0];
      st_neg0 <= nbx[NW-1] ^ sgn_a;
      st_num1 <= NM'(sq_root);
      st_neg1 <= sgn_a;
    end else begin
      st_num0 <= n1m[NM-1:0];
      st_neg0 <= n1[NW-1] ^ sgn_a;
      st_num1 <= n2m[NM-1:0];
      st_neg1 <= n2[NW-1] ^ sgn_a;
    end
  end

  // divide by 2a
  logic                dv_valid;
  logic [NM-1:0]       dv_q0, dv_q1;
  logic                dv_neg0, dv_neg1;
  qrs_pkg::qrs_flags_t dv_flags;

  qrs_div #(.W(W), .F(F)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid),
    .in_num0   (st_num0),
    .in_num1   (st_num1),
    .in_neg0   (st_neg0),
    .in_neg1   (st_neg1),
    .in_den    (st_den),
    .in_flags  (st_flags),
    .out_valid (dv_valid),
    .out_q0    (dv_q0),
    .out_q1    (dv_q1),
    .out_neg0  (dv_neg0),
    .out_neg1  (dv_neg1),
    .out_flags (dv_flags)
  );

  // clip a signed magnitude to the word range; top bit is the clip flag
  function automatic logic [W:0] clip(input logic [NM-1:0] q, input logic neg);
    logic [NM-1:0] lim;
    logic [W-1:0]  mag;
    logic [W:0]    res;
    lim = {{(NM-W+1){1'b0}}, {(W-1){1'b1}}} + NM'(neg);
    mag = q[W-1:0];
    if (q > lim) begin
      res = neg ? {2'b11, {(W-1){1'b0}}} : {2'b10, {(W-1){1'b1}}};
    end else begin
      res = {1'b0, neg ? W'(-mag) : mag};
    end
    return res;
  endfunction

  logic [W:0] c0, c1, c1n;

  assign c0  = clip(dv_q0, dv_neg0);
  assign c1  = clip(dv_q1, dv_neg1);
  assign c1n = clip(dv_q1, ~dv_neg1);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    leading_zero <= dv_flags.azero;
    if (dv_flags.azero) begin
      first_real   <= '0;
      first_imag   <= '0;
      second_real  <= '0;
      second_imag  <= '0;
      complex_pair <= 1'b0;
      saturated    <= 1'b0;
    end else if (dv_flags.dneg) begin
      first_real   <= c0[W-1:0];
      second_real  <= c0[W-1:0];
      first_imag   <= c1[W-1:0];
      second_imag  <= c1n[W-1:0];
      complex_pair <= 1'b1;
      saturated    <= c0[W] | c1[W] | c1n[W];
    end else begin
      first_real   <= c0[W-1:0];
      second_real  <= c1[W-1:0];
      first_imag   <= '0;
      second_imag  <= '0;
      complex_pair <= 1'b0;
      saturated    <= c0[W] | c1[W];
    end
  end

  // checks
  `QRS_ASSERT_NEXT(a_done_follows_div, dv_valid, done)
  `QRS_ASSERT_NOW(a_flags_exclusive, done, !(complex_pair && leading_zero))
  `QRS_ASSERT_NOW(a_real_no_imag, done && !complex_pair, first_imag == '0 && second_imag == '0)
  `QRS_ASSERT_NOW(a_lead_zero_clear, done && leading_zero, first_real == '0 && !saturated)
  `QRS_ASSERT_NOW(a_pair_same_real, done && complex_pair, first_real == second_real)

endmodule

>>> rtl/qrs_front.sv
// ---------------------------------------------------------------------------
// qrs_front
// Input register, coefficient products and discriminant, then the scaled
// radicand |D| * 2^(2F) handed to the square root pipeline. Four stages.
// ---------------------------------------------------------------------------
module qrs_front #(
  parameter int W = qrs_pkg::WORD_BITS_DEF,
  parameter int F = qrs_pkg::FRACTION_BITS_DEF,
  localparam int RB = 2*W + 2 + 2*F
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic signed [W-1:0] in_c,
  output logic                out_valid,
  output logic signed [W-1:0] out_a,
  output logic signed [W-1:0] out_b,
  output logic [RB-1:0]       out_rad,
  output qrs_pkg::qrs_flags_t out_flags
);

  localparam int DW = 2*W + 3;

  // stage 1: input capture
  logic                v1;
  logic signed [W-1:0] a1, b1, c1;
  // stage 2: products
  logic                  v2;
  logic signed [W-1:0]   a2, b2;
  logic signed [2*W-1:0] bb2, ac2;
  // stage 3: discriminant
  logic                v3;
  logic signed [W-1:0] a3, b3;
  logic signed [DW-1:0] d3;
  logic signed [DW-1:0] d_next;
  logic [DW-1:0]        dmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // D = B*B - 4*A*C, exact
  assign d_next = DW'(bb2) - (DW'(ac2) <<< 2);
  assign dmag   = d3[DW-1] ? DW'(-d3) : DW'(d3);

  always_ff @(posedge clk) begin
    a1  <= in_a;
    b1  <= in_b;
    c1  <= in_c;
    a2  <= a1;
    b2  <= b1;
    bb2 <= b1 * b1;
    ac2 <= a1 * c1;
    a3  <= a2;
    b3  <= b2;
    d3  <= d_next;
    out_a <= a3;
    out_b <= b3;
    out_rad <= {1'b0, dmag[2*W:0], {(2*F){1'b0}}};
    out_flags.dneg  <= d3[DW-1];
    out_flags.azero <= (a3 == '0);
  end

endmodule

>>> rtl/qrs_sqrt.sv
// ---------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit integer square root: one root bit per stage,
// SB stages. Coefficients and flags ride along with each request.
// ---------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int W = qrs_pkg::WORD_BITS_DEF,
  parameter int F = qrs_pkg::FRACTION_BITS_DEF,
  localparam int RB = 2*W + 2 + 2*F,
  localparam int SB = RB / 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic [RB-1:0]       in_rad,
  input  qrs_pkg::qrs_flags_t in_flags,
  output logic                out_valid,
  output logic signed [W-1:0] out_a,
  output logic signed [W-1:0] out_b,
  output logic [SB-1:0]       out_root,
  output qrs_pkg::qrs_flags_t out_flags
);

  localparam int RW = SB + 2;

  logic                vld   [0:SB];
  logic signed [W-1:0] sa    [0:SB];
  logic signed [W-1:0] sb    [0:SB];
  logic [RB-1:0]       rad   [0:SB];
  logic [RW-1:0]       rem   [0:SB];
  logic [SB-1:0]       root  [0:SB];
  qrs_pkg::qrs_flags_t flg   [0:SB];

  assign vld[0]  = in_valid;
  assign sa[0]   = in_a;
  assign sb[0]   = in_b;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign flg[0]  = in_flags;

  for (genvar i = 0; i < SB; i++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem[i][RW-3:0], rad[i][RB-1:RB-2]};
    assign trial  = {root[i], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
      root[i+1] <= {root[i][SB-2:0], ge};
      rad[i+1]  <= rad[i] << 2;
      sa[i+1]   <= sa[i];
      sb[i+1]   <= sb[i];
      flg[i+1]  <= flg[i];
    end
  end

  assign out_valid = vld[SB];
  assign out_a     = sa[SB];
  assign out_b     = sb[SB];
  assign out_root  = root[SB];
  assign out_flags = flg[SB];

endmodule

>>> rtl/qrs_div.sv
// ---------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider over magnitudes, one quotient bit per
// stage, NM stages. Both lanes share the denominator 2|a|.
// ---------------------------------------------------------------------------
module qrs_div #(
  parameter int W = qrs_pkg::WORD_BITS_DEF,
  parameter int F = qrs_pkg::FRACTION_BITS_DEF,
  localparam int NM = W + F + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [NM-1:0]       in_num0,
  input  logic [NM-1:0]       in_num1,
  input  logic                in_neg0,
  input  logic                in_neg1,
  input  logic [W:0]          in_den,
  input  qrs_pkg::qrs_flags_t in_flags,
  output logic                out_valid,
  output logic [NM-1:0]       out_q0,
  output logic [NM-1:0]       out_q1,
  output logic                out_neg0,
  output logic                out_neg1,
  output qrs_pkg::qrs_flags_t out_flags
);

  logic                vld [0:NM];
  logic [W:0]          den [0:NM];
  logic                ng0 [0:NM];
  logic                ng1 [0:NM];
  qrs_pkg::qrs_flags_t flg [0:NM];
  logic [NM-1:0]       num [0:NM][2];
  logic [W:0]          rem [0:NM][2];
  logic [NM-1:0]       quo [0:NM][2];

  assign vld[0]    = in_valid;
  assign den[0]    = in_den;
  assign ng0[0]    = in_neg0;
  assign ng1[0]    = in_neg1;
  assign flg[0]    = in_flags;
  assign num[0][0] = in_num0;
  assign num[0][1] = in_num1;
  assign rem[0][0] = '0;
  assign rem[0][1] = '0;
  assign quo[0][0] = '0;
  assign quo[0][1] = '0;

  for (genvar i = 0; i < NM; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      den[i+1] <= den[i];
      ng0[i+1] <= ng0[i];
      ng1[i+1] <= ng1[i];
      flg[i+1] <= flg[i];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [W+1:0] rem_sh;
      logic         ge;

      // shift in next numerator bit, subtract if it fits
      assign rem_sh = {rem[i][l], num[i][l][NM-1]};
      assign ge     = (rem_sh >= {1'b0, den[i]});

      always_ff @(posedge clk) begin
        rem[i+1][l] <= ge ? (W+1)'(rem_sh - {1'b0, den[i]}) : rem_sh[W:0];
        quo[i+1][l] <= {quo[i][l][NM-2:0], ge};
        num[i+1][l] <= num[i][l] << 1;
      end
    end
  end

  assign out_valid = vld[NM];
  assign out_q0    = quo[NM][0];
  assign out_q1    = quo[NM][1];
  assign out_neg0  = ng0[NM];
  assign out_neg1  = ng1[NM];
  assign out_flags = flg[NM];

endmodule

>>> tb/quadratic_root_solver_test.sv
// ---------------------------------------------------------------------------
// quadratic_root_solver_test
// Self-checking bench for the pipelined quadratic root solver. Coefficient
// sets go in through the start/busy handshake. A local predictor works out
// each expected root pair with wide integer arithmetic. Every done strobe is
// checked field by field against the oldest outstanding request.
// ---------------------------------------------------------------------------
module quadratic_root_solver_test;

  localparam int W = qrs_pkg::WORD_BITS_DEF;
  localparam int F = qrs_pkg::FRACTION_BITS_DEF;
  localparam int PIPE_CYCLES = 105;
  localparam logic signed [W-1:0] Q_ONE = 1 <<< F;
  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  typedef logic [127:0] wide_t;
  typedef logic signed [127:0] swide_t;

  typedef struct {
    logic signed [W-1:0] first_real;
    logic signed [W-1:0] first_imag;
    logic signed [W-1:0] second_real;
    logic signed [W-1:0] second_imag;
    logic                complex_pair;
    logic                leading_zero;
    logic                saturated;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] coef_a = '0;
  logic signed [W-1:0] coef_b = '0;
  logic signed [W-1:0] coef_c = '0;
  logic done;
  logic signed [W-1:0] first_real, first_imag, second_real, second_imag;
  logic complex_pair, leading_zero, saturated;

  roots_t pending_roots[$];
  int     err_count = 0;
  int     sent_count = 0;
  int     checked_count = 0;
  int     complex_count = 0;
  int     sat_count = 0;
  int     azero_count = 0;
  int     idle_pct = 0;

  quadratic_root_solver DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done), .first_real(first_real), .first_imag(first_imag),
    .second_real(second_real), .second_imag(second_imag),
    .complex_pair(complex_pair), .leading_zero(leading_zero),
    .saturated(saturated)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor of the square root, one result bit per step
  function automatic wide_t floor_sqrt(input wide_t x);
    wide_t num, res, b;
    num = x;
    res = '0;
    b = wide_t'(1) << 126;
    for (int k = 0; k < 64; k++) begin
      if (num >= res + b) begin
        num = num - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Signed truncating quotient, clipped to the word range
  function automatic logic signed [W-1:0] clip_quot(input bit neg, input wide_t num,
                                                     input wide_t den, inout bit sat);
    wide_t q, lim;
    q = num / den;
    lim = (wide_t'(1) << (W - 1)) - 1 + (neg ? 1 : 0);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic wide_t mag_of(input logic signed [W-1:0] v);
    return v[W-1] ? wide_t'(-{1'b1, v}) & ((wide_t'(1) << W) - 1) : wide_t'(v);
  endfunction

  // Expected roots for one coefficient set
  function automatic roots_t solve_roots(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b,
                                         input logic signed [W-1:0] c);
    roots_t r;
    wide_t ma, mb, mc, bb, fac, dmag, sq, nbm, den;
    swide_t nbs, n1, n2;
    bit sa, sb, sc, dneg, sat, neg_re;
    r = '{default: '0};
    sa = a[W-1];
    sb = b[W-1];
    sc = c[W-1];
    ma = mag_of(a);
    mb = mag_of(b);
    mc = mag_of(c);
    if (ma == 0) begin
      r.leading_zero = 1'b1;
      return r;
    end
    // Discriminant magnitude and sign
    bb = mb * mb;
    fac = (ma * mc) << 2;
    if (sa != sc) begin
      dmag = bb + fac;
      dneg = 1'b0;
    end else if (bb >= fac) begin
      dmag = bb - fac;
      dneg = 1'b0;
    end else begin
      dmag = fac - bb;
      dneg = 1'b1;
    end
    sq = floor_sqrt(dmag << (2 * F));
    nbm = mb << F;
    den = ma << 1;
    sat = 1'b0;
    if (!dneg) begin
      nbs = sb ? swide_t'(nbm) : -swide_t'(nbm);
      n1 = nbs + swide_t'(sq);
      n2 = nbs - swide_t'(sq);
      r.first_real = clip_quot((n1 < 0) ^ sa, n1 < 0 ? wide_t'(-n1) : wide_t'(n1), den, sat);
      r.second_real = clip_quot((n2 < 0) ^ sa, n2 < 0 ? wide_t'(-n2) : wide_t'(n2), den, sat);
    end else begin
      neg_re = (nbm == 0) ? 1'b0 : (!sb) ^ sa;
      r.first_real = clip_quot(neg_re, nbm, den, sat);
      r.second_real = r.first_real;
      r.first_imag = clip_quot(sa, sq, den, sat);
      r.second_imag = clip_quot(!sa, sq, den, sat);
      r.complex_pair = 1'b1;
    end
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    err_count++;
    $display("MISMATCH result %0d %s: got %h expected %h", checked_count, field, got, want);
  endtask

  // Record accepted requests and check every result strobe
  always @(posedge clk) begin
    roots_t exp_r;
    if (start && !busy && !rst) begin
      pending_roots.push_back(solve_roots(coef_a, coef_b, coef_c));
    end
    if (done && !rst) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected done", W'(done), '0);
      end else begin
        exp_r = pending_roots.pop_front();
        if (first_real !== exp_r.first_real)
          report_mismatch("first_real", first_real, exp_r.first_real);
        if (first_imag !== exp_r.first_imag)
          report_mismatch("first_imag", first_imag, exp_r.first_imag);
        if (second_real !== exp_r.second_real)
          report_mismatch("second_real", second_real, exp_r.second_real);
        if (second_imag !== exp_r.second_imag)
          report_mismatch("second_imag", second_imag, exp_r.second_imag);
        if (complex_pair !== exp_r.complex_pair)
          report_mismatch("complex_pair", W'(complex_pair), W'(exp_r.complex_pair));
        if (leading_zero !== exp_r.leading_zero)
          report_mismatch("leading_zero", W'(leading_zero), W'(exp_r.leading_zero));
        if (saturated !== exp_r.saturated)
          report_mismatch("saturated", W'(saturated), W'(exp_r.saturated));
        complex_count += exp_r.complex_pair;
        sat_count += exp_r.saturated;
        azero_count += exp_r.leading_zero;
        checked_count++;
      end
    end
  end

  // Send one request; each cycle in front of it is idle with idle_pct chance
  task automatic send_coefs(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                            input logic signed [W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // Coefficient with a mix of full-range, small and extreme values
  function automatic logic signed [W-1:0] rand_coef();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
      3: return $signed($urandom_range(0, 512)) - 256;
      4: return ($urandom_range(1)) ? W_MAX - $urandom_range(3) : W_MIN + $urandom_range(3);
      default: return $signed($urandom_range(0, 64)) - 32 <<< F;
    endcase
  endfunction

  task automatic test_directed();
    send_coefs('0, Q_ONE, Q_ONE);
    send_coefs('0, '0, '0);
    send_coefs(Q_ONE, -2 * Q_ONE, Q_ONE);
    send_coefs(Q_ONE, '0, -4 * Q_ONE);
    send_coefs(Q_ONE, '0, Q_ONE);
    send_coefs(-Q_ONE, 2 * Q_ONE, -5 * Q_ONE);
    send_coefs(Q_ONE, 2 * Q_ONE, 5 * Q_ONE);
    send_coefs(W_MIN, W_MIN, W_MIN);
    send_coefs(W_MAX, W_MAX, W_MAX);
    send_coefs(W_MIN, W_MAX, W_MIN);
    send_coefs(W_MAX, W_MIN, W_MIN);
    send_coefs(32'sd1, W_MAX, '0);
    send_coefs(-32'sd1, W_MIN, W_MAX);
    send_coefs(32'sd1, '0, W_MAX);
    send_coefs(-32'sd1, '0, W_MAX);
    send_coefs(Q_ONE, '0, '0);
    send_coefs(-1, -1, -1);
    send_coefs(3 * Q_ONE, -7 * Q_ONE, 2 * Q_ONE);
  endtask

  // Real roots: c chosen against a so that -4ac is not negative
  task automatic test_real_roots(input int n);
    logic signed [W-1:0] a, c;
    for (int i = 0; i < n; i++) begin
      a = rand_coef();
      c = rand_coef();
      if (a[W-1] == c[W-1] && c != 0) c = (c == W_MIN) ? W_MAX : -c;
      send_coefs(a, rand_coef(), c);
    end
  endtask

  // Complex pairs: small b; c is negated where its sign differs from a's, unless it is W_MIN
  task automatic test_complex_roots(input int n);
    logic signed [W-1:0] a, c;
    for (int i = 0; i < n; i++) begin
      a = rand_coef();
      c = rand_coef();
      if (a[W-1] != c[W-1] && c != W_MIN) c = -c;
      send_coefs(a, $signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE, c);
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_coefs(($urandom_range(19) == 0) ? '0 : rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES / 4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    idle_pct = 0;
    test_real_roots(150);
    test_complex_roots(150);
    idle_pct = 77;
    test_random(300);
    test_complex_roots(100);
    idle_pct = 0;
    test_random(200);
    idle_pct = 27;
    test_real_roots(100);
    test_random(150);
    drain();
    $display("Sent %0d coefficient sets, checked %0d results", sent_count, checked_count);
    $display("Covered %0d complex pairs, %0d clipped, %0d zero leading terms",
             complex_count, sat_count, azero_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_roots.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
